FILE: rtl/rdac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdac_pkg
// Types, round tables and rotate helpers for the RX-differential ARX checker.
// ----------------------------------------------------------------------------
package rdac_pkg;

	localparam int MAX_ROUNDS  = 12;
	localparam int ROUNDS_DEF  = 12;
	localparam int ROT_K_DEF   = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int FAIL_W      = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VARIANT    = 3'd0,
		REG_DIN_LEFT   = 3'd1,
		REG_DIN_RIGHT  = 3'd2,
		REG_DOUT_LEFT  = 3'd3,
		REG_DOUT_RIGHT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] left_in;
		logic [31:0] right_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] left_out;
		logic [31:0] right_out;
		logic        diff_match;
		logic [FAIL_W-1:0] fail_round;
	} out_item_t;

	// words of both copies plus first failing round
	typedef struct packed {
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] pl;
		logic [31:0] pr;
		logic [FAIL_W-1:0] fail;
	} rdac_state_t;

	localparam logic [31:0] RC0_TAB [2][MAX_ROUNDS] = '{
		'{32'h00000000, 32'h2aaaaaaa, 32'h7fffffff, 32'h55555555,
		  32'h2aaaaaaa, 32'h55555555, 32'h00000000, 32'h2aaaaaaa,
		  32'h55555555, 32'h7fffffff, 32'h7fffffff, 32'h3f2bb31e},
		'{32'h1c71c924, 32'h49249c71, 32'h6db6c71c, 32'h38e39249,
		  32'h638e36db, 32'h1c71c7ff, 32'h36db6d55, 32'h471c7249,
		  32'h4924938e, 32'h2aab6db6, 32'h6db638e3, 32'hfb3d2330}
	};

	localparam logic [31:0] RC1_TAB [2][MAX_ROUNDS] = '{
		'{32'h4e381c1c, 32'h36dbe492, 32'h1236db6c, 32'h0763638e,
		  32'h1b6d4949, 32'h638ef1c7, 32'h47638e39, 32'h5236b6db,
		  32'h4e381c1c, 32'h638eb1c7, 32'h47638e39, 32'hb6c004cc},
		'{32'h249cad47, 32'h1249871c, 32'h5b127ffe, 32'h152ad249,
		  32'h649cad55, 32'h471c9492, 32'h63f1c71d, 32'h36a4ff1c,
		  32'h5b6c8e47, 32'h71c736db, 32'h55b9c71d, 32'hb6da4b61}
	};

	localparam logic [31:0] TRAIL_TAB [2][MAX_ROUNDS] = '{
		'{32'hfffffffc, 32'h7ffffff8, 32'h80000007, 32'h80000007,
		  32'hfffffffc, 32'h00000003, 32'h7ffffff8, 32'hfffffffc,
		  32'h00000003, 32'h7ffffff8, 32'h7ffffff8, 32'h7ffffff8},
		'{32'h7fff8007, 32'h80000007, 32'h0000fff8, 32'h80000003,
		  32'hffff8007, 32'h80000003, 32'hfffff804, 32'hfffffffc,
		  32'h80000ffb, 32'h00000003, 32'h7ff80004, 32'hfffffffc}
	};

	// rotation pairs repeat every four rounds
	localparam logic [4:0] ROT_A_TAB [4] = '{5'd31, 5'd17, 5'd0, 5'd24};
	localparam logic [4:0] ROT_B_TAB [4] = '{5'd24, 5'd17, 5'd31, 5'd16};

	function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] xx;
		xx = {x, x} >> n;
		return xx[31:0];
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] xx;
		xx = {x, x} << n;
		return xx[63:32];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rdac_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdac_round
// One registered round of the ARX box on both copies, with trail check.
// ----------------------------------------------------------------------------
module rdac_round import rdac_pkg::*; #(
	parameter int RND   = 0,
	parameter int ROT_K = ROT_K_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        variant,
	input  wire logic        vld_in,
	input  wire rdac_state_t st_in,
	output logic             vld_out,
	output rdac_state_t      st_out
);

	localparam logic [4:0]        ROT_A   = ROT_A_TAB[RND % 4];
	localparam logic [4:0]        ROT_B   = ROT_B_TAB[RND % 4];
	localparam logic [4:0]        ROT_KK  = 5'(ROT_K);
	localparam logic [FAIL_W-1:0] FAIL_ID = FAIL_W'(RND + 1);

	logic [31:0]       l_add;
	logic [31:0]       pl_add;
	logic [31:0]       delta;
	rdac_state_t       st_nxt;

	always_comb begin
		l_add  = st_in.l + rotr32(st_in.r, ROT_A);
		pl_add = st_in.pl + rotr32(st_in.pr, ROT_A);
		delta  = rotl32(l_add, ROT_KK) ^ pl_add;
		st_nxt.l  = l_add ^ RC0_TAB[variant][RND];
		st_nxt.pl = pl_add ^ RC0_TAB[variant][RND];
		st_nxt.r  = st_in.r ^ rotr32(l_add, ROT_B) ^ RC1_TAB[variant][RND];
		st_nxt.pr = st_in.pr ^ rotr32(pl_add, ROT_B) ^ RC1_TAB[variant][RND];
		// keep the earliest failing round
		if (st_in.fail == '0 && delta != TRAIL_TAB[variant][RND]) begin
			st_nxt.fail = FAIL_ID;
		end else begin
			st_nxt.fail = st_in.fail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		st_out <= st_nxt;
	end

endmodule
`default_nettype wire

FILE: rtl/rdac_final.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdac_final
// Output difference check and result register.
// ----------------------------------------------------------------------------
module rdac_final import rdac_pkg::*; #(
	parameter int ROT_K = ROT_K_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] dout_left,
	input  wire logic [31:0] dout_right,
	input  wire logic        vld_in,
	input  wire rdac_state_t st_in,
	output logic             done,
	output out_item_t        result
);

	localparam logic [4:0] ROT_KK = 5'(ROT_K);

	out_item_t res_nxt;

	always_comb begin
		res_nxt.left_out   = st_in.l;
		res_nxt.right_out  = st_in.r;
		res_nxt.diff_match = (st_in.pl == (rotl32(st_in.l, ROT_KK) ^ dout_left)) &&
			(st_in.pr == (rotl32(st_in.r, ROT_KK) ^ dout_right));
		res_nxt.fail_round = st_in.fail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_nxt;
	end

endmodule
`default_nettype wire

FILE: rtl/rx_differential_arx_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rx_differential_arx_checker
// RX-differential check of a multi-round ARX box against a stored trail.
// ----------------------------------------------------------------------------
// A new pair is taken in every cycle (busy is always low). Each result passes
// through one entry stage that forms the partner words, one register stage
// per round (one 32-bit add per copy and the trail compare), and one result
// stage that does the output difference check. done is high for one cycle
// with the result; there is no holdoff, so the receiver must take it then.
// Configuration writes take effect at once and are meant to be done while no
// item is in flight.
module rx_differential_arx_checker import rdac_pkg::*; #(
	parameter int ROUNDS = ROUNDS_DEF,
	parameter int ROT_K  = ROT_K_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_item_t             item,
	output logic                      done,
	output out_item_t                 result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [31:0]          cfg_wdata
);

	localparam int         NR     = (ROUNDS > MAX_ROUNDS) ? MAX_ROUNDS : ROUNDS;
	localparam logic [4:0] ROT_KK = 5'(ROT_K);

	logic        variant_q;
	logic [31:0] din_left_q;
	logic [31:0] din_right_q;
	logic [31:0] dout_left_q;
	logic [31:0] dout_right_q;

	logic        vld_s0;
	rdac_state_t st_s0;

	logic        vld_chain [NR+1];
	rdac_state_t st_chain  [NR+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q    <= 1'b0;
			din_left_q   <= 32'h7ffffff8;
			din_right_q  <= 32'h3ffffffe;
			dout_left_q  <= 32'hb989d417;
			dout_right_q <= 32'h0347a2a9;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_VARIANT:    variant_q    <= cfg_wdata[0];
				REG_DIN_LEFT:   din_left_q   <= cfg_wdata;
				REG_DIN_RIGHT:  din_right_q  <= cfg_wdata;
				REG_DOUT_LEFT:  dout_left_q  <= cfg_wdata;
				REG_DOUT_RIGHT: dout_right_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// entry stage: first copy as given, partner copy rotated plus difference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		st_s0.l    <= item.left_in;
		st_s0.r    <= item.right_in;
		st_s0.pl   <= rotl32(item.left_in, ROT_KK) ^ din_left_q;
		st_s0.pr   <= rotl32(item.right_in, ROT_KK) ^ din_right_q;
		st_s0.fail <= '0;
	end

	assign vld_chain[0] = vld_s0;
	assign st_chain[0]  = st_s0;

	for (genvar g = 0; g < NR; g++) begin : g_round
		rdac_round #(
			.RND   (g),
			.ROT_K (ROT_K)
		) u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.variant (variant_q),
			.vld_in  (vld_chain[g]),
			.st_in   (st_chain[g]),
			.vld_out (vld_chain[g+1]),
			.st_out  (st_chain[g+1])
		);
	end

	rdac_final #(
		.ROT_K (ROT_K)
	) u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.dout_left  (dout_left_q),
		.dout_right (dout_right_q),
		.vld_in     (vld_chain[NR]),
		.st_in      (st_chain[NR]),
		.done       (done),
		.result     (result)
	);

endmodule
`default_nettype wire

FILE: verif/rx_differential_arx_checker_tb.sv
// ----------------------------------------------------------------------------
// rx_differential_arx_checker_tb
// Drives input pairs through the RX-differential ARX checker and compares
// every result against a behavioral twelve-round ARX box model kept in the
// bench. It covers field extremes, both constant sets, register masking,
// writes to unused indices, a forced output difference match and pairs picked
// to follow the trail deep. Then it runs randomized phases with varied
// register settings and input gaps.
// ----------------------------------------------------------------------------
module rx_differential_arx_checker_tb;
	import rdac_pkg::*;

	localparam int ROUNDS_N    = 12;
	localparam int ROT_K_N     = 3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 250;

	localparam logic [31:0] RESET_DIN_LEFT   = 32'h7ffffff8;
	localparam logic [31:0] RESET_DIN_RIGHT  = 32'h3ffffffe;
	localparam logic [31:0] RESET_DOUT_LEFT  = 32'hb989d417;
	localparam logic [31:0] RESET_DOUT_RIGHT = 32'h0347a2a9;

	// round constants per variant: left word, right word
	localparam logic [31:0] KEY_L [2][12] = '{
		'{32'h00000000, 32'h2aaaaaaa, 32'h7fffffff, 32'h55555555,
		  32'h2aaaaaaa, 32'h55555555, 32'h00000000, 32'h2aaaaaaa,
		  32'h55555555, 32'h7fffffff, 32'h7fffffff, 32'h3f2bb31e},
		'{32'h1c71c924, 32'h49249c71, 32'h6db6c71c, 32'h38e39249,
		  32'h638e36db, 32'h1c71c7ff, 32'h36db6d55, 32'h471c7249,
		  32'h4924938e, 32'h2aab6db6, 32'h6db638e3, 32'hfb3d2330}
	};
	localparam logic [31:0] KEY_R [2][12] = '{
		'{32'h4e381c1c, 32'h36dbe492, 32'h1236db6c, 32'h0763638e,
		  32'h1b6d4949, 32'h638ef1c7, 32'h47638e39, 32'h5236b6db,
		  32'h4e381c1c, 32'h638eb1c7, 32'h47638e39, 32'hb6c004cc},
		'{32'h249cad47, 32'h1249871c, 32'h5b127ffe, 32'h152ad249,
		  32'h649cad55, 32'h471c9492, 32'h63f1c71d, 32'h36a4ff1c,
		  32'h5b6c8e47, 32'h71c736db, 32'h55b9c71d, 32'hb6da4b61}
	};
	localparam logic [31:0] TRAIL [2][12] = '{
		'{32'hfffffffc, 32'h7ffffff8, 32'h80000007, 32'h80000007,
		  32'hfffffffc, 32'h00000003, 32'h7ffffff8, 32'hfffffffc,
		  32'h00000003, 32'h7ffffff8, 32'h7ffffff8, 32'h7ffffff8},
		'{32'h7fff8007, 32'h80000007, 32'h0000fff8, 32'h80000003,
		  32'hffff8007, 32'h80000003, 32'hfffff804, 32'hfffffffc,
		  32'h80000ffb, 32'h00000003, 32'h7ff80004, 32'hfffffffc}
	};
	localparam int ADD_ROT [4] = '{31, 17, 0, 24};
	localparam int XOR_ROT [4] = '{24, 17, 31, 16};

	typedef struct packed {
		out_item_t   box;
		logic [31:0] partner_l;
		logic [31:0] partner_r;
	} arx_eval_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	in_item_t             item = '0;
	logic                 done;
	out_item_t            result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [31:0]          cfg_wdata = '0;

	// register copies, starting from their reset values
	logic        variant_q   = 1'b0;
	logic [31:0] din_left_q  = RESET_DIN_LEFT;
	logic [31:0] din_right_q = RESET_DIN_RIGHT;
	logic [31:0] dout_left_q = RESET_DOUT_LEFT;
	logic [31:0] dout_right_q = RESET_DOUT_RIGHT;

	out_item_t box_outputs_q[$];
	out_item_t want_box;
	int        mismatch_cnt = 0;
	int        stall_cycles = 0;

	rx_differential_arx_checker #(
		.ROUNDS(ROUNDS_N),
		.ROT_K (ROT_K_N)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		n = n % 32;
		return (n == 0) ? x : ((x >> n) | (x << (32 - n)));
	endfunction

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		n = n % 32;
		return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
	endfunction

	// runs both copies in lockstep and tracks the first round off the trail
	function automatic arx_eval_t arx_box_eval(input in_item_t x);
		logic [31:0] l, r, pl, pr;
		logic [3:0]  fail;
		int          v;
		arx_eval_t   e;
		l = x.left_in;
		r = x.right_in;
		pl = rol(l, ROT_K_N) ^ din_left_q;
		pr = rol(r, ROT_K_N) ^ din_right_q;
		v = variant_q;
		fail = '0;
		for (int i = 0; i < ROUNDS_N && i < 12; i++) begin
			l = l + ror(r, ADD_ROT[i % 4]);
			pl = pl + ror(pr, ADD_ROT[i % 4]);
			if (fail == 0 && (rol(l, ROT_K_N) ^ pl) != TRAIL[v][i])
				fail = 4'(i + 1);
			r = r ^ ror(l, XOR_ROT[i % 4]);
			pr = pr ^ ror(pl, XOR_ROT[i % 4]);
			l = l ^ KEY_L[v][i];
			pl = pl ^ KEY_L[v][i];
			r = r ^ KEY_R[v][i];
			pr = pr ^ KEY_R[v][i];
		end
		e.box.left_out = l;
		e.box.right_out = r;
		e.box.diff_match = (pl == (rol(l, ROT_K_N) ^ dout_left_q)) &&
			(pr == (rol(r, ROT_K_N) ^ dout_right_q));
		e.box.fail_round = fail;
		e.partner_l = pl;
		e.partner_r = pr;
		return e;
	endfunction

	// best of several random pairs by how far they stay on the trail
	function automatic in_item_t deepest_pair(input int tries);
		in_item_t  x, best;
		arx_eval_t e;
		int        score, best_score;
		best = '0;
		best_score = -1;
		for (int t = 0; t < tries; t++) begin
			x.left_in = $urandom;
			x.right_in = $urandom;
			e = arx_box_eval(x);
			score = (e.box.fail_round == 0) ? 13 : e.box.fail_round;
			if (score > best_score) begin
				best_score = score;
				best = x;
			end
		end
		return best;
	endfunction

	task automatic send_pair(input in_item_t x);
		arx_eval_t e;
		@(negedge clk);
		start <= 1'b1;
		cfg_we <= 1'b0;
		item <= x;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		e = arx_box_eval(x);
		box_outputs_q.push_back(e.box);
	endtask

	task automatic idle_gap(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		cfg_we <= 1'b0;
		while (box_outputs_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		start <= 1'b0;
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_VARIANT:    variant_q = val[0];
			REG_DIN_LEFT:   din_left_q = val;
			REG_DIN_RIGHT:  din_right_q = val;
			REG_DOUT_LEFT:  dout_left_q = val;
			REG_DOUT_RIGHT: dout_right_q = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] v, input logic [31:0] dl,
			input logic [31:0] dr, input logic [31:0] ol, input logic [31:0] orr);
		wait_drained();
		write_reg(REG_VARIANT, v);
		write_reg(REG_DIN_LEFT, dl);
		write_reg(REG_DIN_RIGHT, dr);
		write_reg(REG_DOUT_LEFT, ol);
		write_reg(REG_DOUT_RIGHT, orr);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (box_outputs_q.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatch_cnt++;
			end else begin
				want_box = box_outputs_q.pop_front();
				check_field("left_out", want_box.left_out, result.left_out);
				check_field("right_out", want_box.right_out, result.right_out);
				check_field("diff_match", want_box.diff_match, result.diff_match);
				check_field("fail_round", want_box.fail_round, result.fail_round);
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// runs on the register values left by reset
	task automatic test_field_extremes();
		send_pair('{32'h00000000, 32'h00000000});
		send_pair('{32'hffffffff, 32'hffffffff});
		send_pair('{32'h00000000, 32'hffffffff});
		send_pair('{32'hffffffff, 32'h00000000});
		send_pair('{32'h80000000, 32'h00000001});
		send_pair('{32'h00000001, 32'h80000000});
		send_pair('{32'haaaaaaaa, 32'h55555555});
	endtask

	// only bit 0 of the variant write counts
	task automatic test_variant_select();
		wait_drained();
		write_reg(REG_VARIANT, 32'hffffffff);
		send_pair('{32'h00000000, 32'h00000000});
		send_pair('{$urandom, $urandom});
		wait_drained();
		write_reg(REG_VARIANT, 32'hfffffffe);
		send_pair('{$urandom, $urandom});
	endtask

	task automatic test_spare_index();
		wait_drained();
		for (int i = REG_DOUT_RIGHT + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), $urandom);
		send_pair('{$urandom, $urandom});
		send_pair('{$urandom, $urandom});
	endtask

	// set the output difference registers from a known pair so it matches
	task automatic test_output_difference();
		in_item_t  x;
		arx_eval_t e;
		for (int v = 0; v < 2; v++) begin
			wait_drained();
			write_reg(REG_VARIANT, v);
			x = '{$urandom, $urandom};
			e = arx_box_eval(x);
			write_reg(REG_DOUT_LEFT, e.partner_l ^ rol(e.box.left_out, ROT_K_N));
			write_reg(REG_DOUT_RIGHT, e.partner_r ^ rol(e.box.right_out, ROT_K_N));
			send_pair(x);
			send_pair('{x.left_in, ~x.right_in});
			wait_drained();
			// left still matches, right is one bit off
			write_reg(REG_DOUT_RIGHT, dout_right_q ^ 32'h00000001);
			send_pair(x);
		end
	endtask

	task automatic test_trail_depth();
		for (int v = 0; v < 2; v++) begin
			write_all(v, RESET_DIN_LEFT, RESET_DIN_RIGHT, RESET_DOUT_LEFT,
				RESET_DOUT_RIGHT);
			repeat (3) send_pair(deepest_pair(2048));
		end
	endtask

	task automatic test_random_traffic();
		in_item_t x;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_all(0, RESET_DIN_LEFT, RESET_DIN_RIGHT, $urandom, $urandom);
				1: write_all(1, 32'h0, 32'h0, 32'hffffffff, 32'hffffffff);
				2: write_all($urandom, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0);
				default: write_all($urandom, $urandom, $urandom, $urandom, $urandom);
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0)
					x = deepest_pair(16);
				else
					x = '{$urandom, $urandom};
				send_pair(x);
				// last phase runs back to back
				if (phase != 3 && $urandom_range(0, 3) == 0)
					idle_gap($urandom_range(1, 5));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_variant_select();
		test_spare_index();
		test_output_difference();
		test_trail_depth();
		test_random_traffic();
		wait_drained();
		repeat (ROUNDS_N + 4) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/rdac_pkg.sv
rtl/rdac_round.sv
rtl/rdac_final.sv
rtl/rx_differential_arx_checker.sv
verif/rx_differential_arx_checker_tb.sv
